FILE: design/sscd_pkg.sv
// ----------------------------------------------------------------------------
// sscd_pkg
// shared constants, types and helpers of the speed command sentence decoder
// ----------------------------------------------------------------------------
package sscd_pkg;

  // character codes
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_END   = 8'h2A;  // '*'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // field limits
  localparam int TYPE_MAX_DEF    = 5;
  localparam int PAYLOAD_MAX_DEF = 4;
  localparam int MATCH_LEN       = 5;
  localparam int MATCH_IDX_W     = 3;

  localparam int BYTE_W   = 8;
  localparam int PERIOD_W = 15;
  localparam int LIMIT_W  = 14;
  localparam int MAG_W    = 14;
  localparam int SPEED_W  = 15;
  localparam int DUTY_W   = 16;
  localparam int PROD_W   = PERIOD_W + MAG_W;

  localparam logic [MAG_W-1:0]  MAG_CAP  = 14'd16383;
  localparam logic [DUTY_W-1:0] DUTY_CAP = 16'd65535;

  // floor(n / 500) as floor((n >> 2) / 125) by reciprocal, exact for n < 2^29
  localparam int QUOT_IN_W   = PROD_W - 2;
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP = 28'd137438954;
  localparam int RECIP_PROD_W = QUOT_IN_W + RECIP_W;
  localparam int QUOT_W       = RECIP_PROD_W - RECIP_SHIFT;

  // configuration
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_LIMIT  = 1'd1;
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 15'd1842;
  localparam logic [LIMIT_W-1:0]  RPM_LIMIT_RST  = 14'd1000;

  // completed sentence handed from the parser to the duty stage
  typedef struct packed {
    logic                      matched;
    logic                      accepted;
    logic signed [SPEED_W-1:0] speed;
    logic [PROD_W-1:0]         prod;
  } res_t;

  // expected type character at a given position of MCREF
  function automatic logic [BYTE_W-1:0] match_char(input logic [MATCH_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h4D;  // 'M'
      3'd1:    ch = 8'h43;  // 'C'
      3'd2:    ch = 8'h52;  // 'R'
      3'd3:    ch = 8'h45;  // 'E'
      3'd4:    ch = 8'h46;  // 'F'
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: design/sscd_parser.sv
// ----------------------------------------------------------------------------
// sscd_parser
// input byte register, sentence parse state and completed sentence register
// ----------------------------------------------------------------------------
module sscd_parser #(
  parameter int TYPE_MAX    = sscd_pkg::TYPE_MAX_DEF,
  parameter int PAYLOAD_MAX = sscd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sscd_pkg::BYTE_W-1:0]    in_byte,
  input  logic [sscd_pkg::PERIOD_W-1:0]  pwm_period,
  input  logic [sscd_pkg::LIMIT_W-1:0]   rpm_limit,
  output logic                           res_valid,
  input  logic                           res_ready,
  output sscd_pkg::res_t                 res
);
  import sscd_pkg::*;

  localparam int TC_W = $clog2(TYPE_MAX + 1);
  localparam int PC_W = $clog2(PAYLOAD_MAX + 1);

  localparam logic [1:0] MODE_HUNT    = 2'd0;
  localparam logic [1:0] MODE_TYPE    = 2'd1;
  localparam logic [1:0] MODE_PAYLOAD = 2'd2;

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_reg;

  logic [1:0]       mode, mode_next;
  logic [TC_W-1:0]  type_count, type_count_next;
  logic             type_match, type_match_next;
  logic [PC_W-1:0]  payload_count, payload_count_next;
  logic             value_negative, value_negative_next;
  logic [MAG_W-1:0] value_magnitude, value_magnitude_next;
  logic             value_closed, value_closed_next;

  logic             is_end;
  logic             res_free;
  logic             consume;
  logic             nonneg;
  logic [MAG_W+3:0] mag_step;
  res_t             res_next;

  assign is_end   = (mode == MODE_PAYLOAD) && (byte_reg == CH_END);
  assign res_free = !res_valid || res_ready;
  assign consume  = byte_valid && (!is_end || res_free);
  assign in_ready = !byte_valid || consume;

  // magnitude times ten plus the new digit
  assign mag_step = (MAG_W+4)'(value_magnitude) * (MAG_W+4)'(10)
                  + (MAG_W+4)'(byte_reg - CH_ZERO);

  assign nonneg = !value_negative || (value_magnitude == '0);

  always_comb begin
    res_next.matched  = type_match;
    res_next.accepted = type_match && nonneg && (value_magnitude <= rpm_limit);
    res_next.speed    = value_negative ? -$signed({1'b0, value_magnitude})
                                       : $signed({1'b0, value_magnitude});
    res_next.prod     = PROD_W'(pwm_period) * PROD_W'(value_magnitude);
  end

  always_comb begin
    mode_next            = mode;
    type_count_next      = type_count;
    type_match_next      = type_match;
    payload_count_next   = payload_count;
    value_negative_next  = value_negative;
    value_magnitude_next = value_magnitude;
    value_closed_next    = value_closed;
    unique case (mode)
      MODE_TYPE: begin
        if (byte_reg == CH_COMMA) begin
          type_match_next      = type_match && (type_count == TC_W'(MATCH_LEN));
          mode_next            = MODE_PAYLOAD;
          payload_count_next   = '0;
          value_negative_next  = 1'b0;
          value_magnitude_next = '0;
          value_closed_next    = 1'b0;
        end else if (type_count >= TC_W'(TYPE_MAX)) begin
          mode_next       = MODE_HUNT;
          type_count_next = '0;
        end else begin
          if (type_count >= TC_W'(MATCH_LEN) ||
              byte_reg != match_char(MATCH_IDX_W'(type_count)))
            type_match_next = 1'b0;
          type_count_next = type_count + 1'b1;
        end
      end
      MODE_PAYLOAD: begin
        if (byte_reg == CH_END) begin
          mode_next = MODE_HUNT;
        end else if (payload_count >= PC_W'(PAYLOAD_MAX)) begin
          mode_next          = MODE_HUNT;
          payload_count_next = '0;
        end else begin
          payload_count_next = payload_count + 1'b1;
          if (!value_closed) begin
            if (byte_reg == CH_COMMA) begin
              value_closed_next = 1'b1;
            end else if (payload_count == '0 &&
                         (byte_reg == CH_MINUS || byte_reg == CH_PLUS)) begin
              value_negative_next = (byte_reg == CH_MINUS);
            end else if (byte_reg >= CH_ZERO && byte_reg <= CH_NINE) begin
              value_magnitude_next = (mag_step > (MAG_W+4)'(MAG_CAP)) ? MAG_CAP
                                                                    : mag_step[MAG_W-1:0];
            end
          end
        end
      end
      default: begin
        // hunt, unused code too
        mode_next = MODE_HUNT;
        if (byte_reg == CH_START) begin
          mode_next       = MODE_TYPE;
          type_count_next = '0;
          type_match_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_reg <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_HUNT;
      type_count      <= '0;
      type_match      <= 1'b1;
      payload_count   <= '0;
      value_negative  <= 1'b0;
      value_magnitude <= '0;
      value_closed    <= 1'b0;
    end else if (consume) begin
      mode            <= mode_next;
      type_count      <= type_count_next;
      type_match      <= type_match_next;
      payload_count   <= payload_count_next;
      value_negative  <= value_negative_next;
      value_magnitude <= value_magnitude_next;
      value_closed    <= value_closed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= consume && is_end;
    end
    if (res_free && consume && is_end) begin
      res <= res_next;
    end
  end

endmodule

FILE: design/sscd_duty.sv
// ----------------------------------------------------------------------------
// sscd_duty
// duty scaling by reciprocal, duty register and result output register
// ----------------------------------------------------------------------------
module sscd_duty (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               res_valid,
  output logic                               res_ready,
  input  sscd_pkg::res_t                     res,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_matched,
  output logic                               out_accepted,
  output logic signed [sscd_pkg::SPEED_W-1:0] out_speed,
  output logic [sscd_pkg::DUTY_W-1:0]        out_duty
);
  import sscd_pkg::*;

  logic                      q_valid;
  logic                      q_matched;
  logic                      q_accepted;
  logic signed [SPEED_W-1:0] q_speed;
  logic [QUOT_W-1:0]         q_quot;

  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [DUTY_W-1:0]       duty_sat;
  logic [DUTY_W-1:0]       duty_register;
  logic                    out_free;

  assign out_free  = !out_valid || out_ready;
  assign res_ready = !q_valid || out_free;

  // floor(prod / 500): drop two bits, then divide by 125 with the reciprocal
  assign recip_prod = RECIP_PROD_W'(res.prod[PROD_W-1:2]) * RECIP_PROD_W'(RECIP);

  assign duty_sat = (q_quot > QUOT_W'(DUTY_CAP)) ? DUTY_CAP : q_quot[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (res_ready) begin
      q_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      q_matched  <= res.matched;
      q_accepted <= res.accepted;
      q_speed    <= res.speed;
      q_quot     <= recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      duty_register <= '0;
    end else if (out_free) begin
      out_valid <= q_valid;
      if (q_valid && q_accepted) begin
        duty_register <= duty_sat;
      end
    end
    if (out_free && q_valid) begin
      out_matched  <= q_matched;
      out_accepted <= q_accepted;
      out_speed    <= q_speed;
    end
  end

  assign out_duty = duty_register;

endmodule

FILE: design/sentence_speed_command_decoder_core.sv
// ----------------------------------------------------------------------------
// sentence_speed_command_decoder_core
// parses $TYPE,PAYLOAD* speed command sentences and holds the pwm duty value
// ----------------------------------------------------------------------------
// usage
//   s_tvalid/s_tready/s_tdata carry one received character per word. a new word
//   may follow each cycle while no closing '*' waits for the result side.
//   a '*' that closes a sentence produces one word on m_tvalid/m_tready/
//   m_tdata; all other characters produce nothing.
//   from the closing '*' being accepted to its result word on m_tvalid, the
//   character lands in the input register, then moves through the parse and
//   product register and the reciprocal divide register into the output
//   register. the duty scaling multiply (period times value) and the
//   divide-by-500 reciprocal multiply sit in separate stages; the duty
//   register updates in the output stage.
//   when the receiver stalls, characters keep flowing through the parser;
//   only a closing '*' waits when all three result stages are full.
//   cfg_valid/cfg_index/cfg_data write pwm_period (index 0) and rpm_limit
//   (index 1); cfg_ready is always high. write only while no sentence result
//   is in flight.
//   synchronous reset restores pwm_period 1842, rpm_limit 1000, clears the
//   duty register, empties the pipeline and hunts for '$'.
// ----------------------------------------------------------------------------
module sentence_speed_command_decoder_core #(
  parameter int TYPE_MAX    = sscd_pkg::TYPE_MAX_DEF,
  parameter int PAYLOAD_MAX = sscd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] type_matched, [1] value_accepted, [16:2] speed_value,
  // [32:17] duty_value, [39:33] zero
  output logic [39:0]                       m_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sscd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sscd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sscd_pkg::*;

  logic [PERIOD_W-1:0] pwm_period;
  logic [LIMIT_W-1:0]  rpm_limit;

  logic res_valid;
  logic res_ready;
  res_t res;

  logic                      out_matched;
  logic                      out_accepted;
  logic signed [SPEED_W-1:0] out_speed;
  logic [DUTY_W-1:0]         out_duty;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PWM_PERIOD_RST;
      rpm_limit  <= RPM_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PWM_PERIOD: pwm_period <= cfg_data[PERIOD_W-1:0];
        CFG_RPM_LIMIT:  rpm_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // character parser and sentence completion
  sscd_parser #(
    .TYPE_MAX    (TYPE_MAX),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .pwm_period (pwm_period),
    .rpm_limit  (rpm_limit),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // duty scaling and result register
  sscd_duty u_duty (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_matched  (out_matched),
    .out_accepted (out_accepted),
    .out_speed    (out_speed),
    .out_duty     (out_duty)
  );

  assign m_tdata = {7'd0, out_duty, out_speed, out_accepted, out_matched};

  // an accepted value always comes from a matched type
  a_accept_needs_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
    else $error("value accepted without type match");

  // an accepted speed is never negative
  a_accept_nonneg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> !m_tdata[16])
    else $error("negative speed accepted");

  // input backpressure only arises from a stalled, full result side
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while result side is free");

endmodule
